FILE: rtl/fms_pkg.sv
// Shared types, codes and constants of the fingerprint module sequencer.
package fms_pkg;

  // Fixed packet and field sizes
  localparam int PACKET_BYTES  = 12;
  localparam int ENROLL_PASSES = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int REPLY_IDX_W   = 4;

  // Event codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_BYTE   = 3'd1;
  localparam logic [2:0] ACT_VERIFY = 3'd2;
  localparam logic [2:0] ACT_UNLOCK = 3'd3;
  localparam logic [2:0] ACT_ENROLL = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ID   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_WIDTH_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_WIDTH_B = 2'd3;

  // Register reset values
  localparam logic [15:0] DEVICE_ID_RST    = 16'd1;
  localparam logic        CAPTURE_RST      = 1'b1;
  localparam logic [15:0] LOCK_WIDTH_A_RST = 16'd750;
  localparam logic [15:0] LOCK_WIDTH_B_RST = 16'd2000;

  // Packet bytes and module command codes
  localparam logic [7:0] HDR_0        = 8'h55;
  localparam logic [7:0] HDR_1        = 8'hAA;
  localparam logic [7:0] ACK_CODE     = 8'h30;
  localparam logic [7:0] CMD_LED      = 8'h12;
  localparam logic [7:0] CMD_ENR_START = 8'h22;
  localparam logic [7:0] CMD_ENR_PASS = 8'h23;
  localparam logic [7:0] CMD_PRESS    = 8'h26;
  localparam logic [7:0] CMD_IDENT    = 8'h51;
  localparam logic [7:0] CMD_CAPTURE  = 8'h60;
  localparam logic [7:0] CMD_CLEAR    = 8'h41;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PACKET  = 2'd0,
    KIND_SUCCESS = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // Dialog phases
  typedef enum logic [3:0] {
    PH_ENR_START = 4'd0,
    PH_LED_ON    = 4'd1,
    PH_CAPTURE   = 4'd2,
    PH_LED_OFF   = 4'd3,
    PH_ENR_PASS  = 4'd4,
    PH_ON_ENR    = 4'd5,
    PH_OFF_ENR   = 4'd6,
    PH_IDENT     = 4'd7,
    PH_ON_VER    = 4'd8,
    PH_OFF_VER   = 4'd9,
    PH_CLEAR     = 4'd10,
    PH_IDLE      = 4'd11
  } phase_t;

  // One unit of work for the back end: a command packet or a pulse
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cmd;
    logic [15:0] param;
    logic [15:0] servo_width;
  } job_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [15:0] device_id;
    logic        capture_param;
    logic [15:0] lock_width_a;
    logic [15:0] lock_width_b;
  } cfg_t;

endpackage

FILE: rtl/fms_if.sv
// Channel interfaces: event input, result output and configuration write.
interface fms_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface fms_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] servo_width;
  modport source (output valid, kind, tx_byte, last, servo_width, input ready);
  modport sink (input valid, kind, tx_byte, last, servo_width, output ready);
endinterface

interface fms_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fms_pkg::CFG_INDEX_W-1:0] index;
  logic [fms_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/fms_front.sv
// Front end: takes events, runs the dialog phase machine, queues work.
module fms_front #(
  parameter int ENROLL_PASSES = fms_pkg::ENROLL_PASSES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  output logic              evt_ready,
  input  logic [2:0]        action,
  input  logic [7:0]        rx_byte,
  input  fms_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output fms_pkg::job_t     push_job
);
  import fms_pkg::*;

  phase_t                 phase, phase_next;
  phase_t                 phase_after, after_next;
  logic                   first_visit, first_next;
  logic                   reply_complete, complete_next;
  logic [REPLY_IDX_W-1:0] reply_count, count_next;
  logic [7:0]             reply_bytes [PACKET_BYTES];
  logic [15:0]            enroll_slot, slot_next;
  logic [1:0]             enroll_pass, pass_next;
  logic                   lock_at_b, lock_next;

  logic        accept;
  logic        send;
  logic        pulse;
  kind_t       pulse_kind;
  logic [7:0]  cmd;
  logic [15:0] param;
  logic        ack;
  logic        byte_we;

  assign evt_ready = !q_full;
  assign accept    = evt_valid && evt_ready;
  assign ack       = reply_bytes[8] == ACK_CODE;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CLEAR;
      phase_after    <= PH_ENR_START;
      first_visit    <= 1'b1;
      reply_complete <= 1'b0;
      reply_count    <= '0;
      enroll_slot    <= 16'd1;
      enroll_pass    <= 2'd0;
      lock_at_b      <= 1'b0;
    end else begin
      phase          <= phase_next;
      phase_after    <= after_next;
      first_visit    <= first_next;
      reply_complete <= complete_next;
      reply_count    <= count_next;
      enroll_slot    <= slot_next;
      enroll_pass    <= pass_next;
      lock_at_b      <= lock_next;
    end
  end

  // Reply store; every entry is rewritten before the reply counts as complete
  always_ff @(posedge clk) begin
    if (byte_we) begin
      reply_bytes[reply_count] <= rx_byte;
    end
  end

  // Next state and queued work
  always_comb begin
    phase_next    = phase;
    after_next    = phase_after;
    first_next    = first_visit;
    complete_next = reply_complete;
    count_next    = reply_count;
    slot_next     = enroll_slot;
    pass_next     = enroll_pass;
    lock_next     = lock_at_b;
    send          = 1'b0;
    pulse         = 1'b0;
    pulse_kind    = KIND_SUCCESS;
    cmd           = 8'h00;
    param         = 16'h0000;
    byte_we       = 1'b0;
    if (accept) begin
      unique case (action)
        ACT_TICK: begin
          if (phase == PH_CLEAR) begin
            phase_next = PH_IDLE;
            send       = 1'b1;
            cmd        = CMD_CLEAR;
          end else if (phase < PH_CLEAR) begin
            if (first_visit) begin
              first_next = 1'b0;
              send       = 1'b1;
              unique case (phase)
                PH_ENR_START: begin
                  cmd   = CMD_ENR_START;
                  param = enroll_slot;
                end
                PH_LED_ON: begin
                  cmd   = CMD_LED;
                  param = 16'd1;
                end
                PH_CAPTURE: begin
                  cmd   = CMD_CAPTURE;
                  param = {15'd0, cfg.capture_param};
                end
                PH_LED_OFF: cmd = CMD_LED;
                PH_ENR_PASS: cmd = CMD_ENR_PASS + {6'd0, enroll_pass};
                PH_IDENT: cmd = CMD_IDENT;
                default: cmd = CMD_PRESS;
              endcase
            end else if (reply_complete) begin
              unique case (phase)
                PH_ENR_START: begin
                  if (ack) begin
                    phase_next = PH_LED_ON;
                    after_next = PH_ON_ENR;
                    first_next = 1'b1;
                  end
                end
                PH_LED_ON, PH_LED_OFF: begin
                  if (ack) begin
                    phase_next = phase_after;
                    first_next = 1'b1;
                  end
                end
                PH_CAPTURE: begin
                  // a missed capture is retried by resending
                  if (ack) begin
                    phase_next = phase_after;
                  end
                  first_next = 1'b1;
                end
                PH_ON_ENR, PH_ON_VER: begin
                  if (ack) begin
                    first_next = 1'b1;
                    if (reply_bytes[4] == 8'h00) begin
                      phase_next = PH_CAPTURE;
                      after_next = (phase == PH_ON_ENR) ? PH_ENR_PASS : PH_IDENT;
                    end
                  end
                end
                PH_OFF_ENR, PH_OFF_VER: begin
                  if (ack) begin
                    first_next = 1'b1;
                    if (reply_bytes[4] != 8'h00 || reply_bytes[5] != 8'h00) begin
                      phase_next = PH_LED_ON;
                      after_next = (phase == PH_OFF_ENR) ? PH_ON_ENR : PH_ON_VER;
                    end
                  end
                end
                PH_ENR_PASS: begin
                  phase_next = PH_LED_OFF;
                  first_next = 1'b1;
                  if (!ack) begin
                    pass_next  = 2'd0;
                    after_next = PH_ENR_START;
                  end else if ({1'b0, enroll_pass} + 3'd1 >= 3'(ENROLL_PASSES)) begin
                    // last pass: template stored
                    after_next = PH_IDLE;
                    slot_next  = enroll_slot + 16'd1;
                    pass_next  = 2'd0;
                    pulse      = 1'b1;
                  end else begin
                    pass_next  = enroll_pass + 2'd1;
                    after_next = PH_OFF_ENR;
                  end
                end
                PH_IDENT: begin
                  phase_next = PH_LED_OFF;
                  after_next = PH_IDLE;
                  first_next = 1'b1;
                  pulse      = 1'b1;
                  if (ack) begin
                    lock_next = !lock_at_b;
                  end else begin
                    pulse_kind = KIND_REJECT;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ACT_BYTE: begin
          if (reply_count < REPLY_IDX_W'(PACKET_BYTES)) begin
            byte_we    = 1'b1;
            count_next = reply_count + 1'b1;
            if (count_next == REPLY_IDX_W'(PACKET_BYTES)) begin
              complete_next = 1'b1;
            end
          end
        end
        ACT_VERIFY: begin
          phase_next = PH_LED_ON;
          after_next = PH_ON_VER;
          first_next = 1'b1;
        end
        ACT_UNLOCK: begin
          lock_next = !lock_at_b;
          pulse     = 1'b1;
        end
        ACT_ENROLL: begin
          phase_next = PH_LED_OFF;
          after_next = PH_ENR_START;
        end
        default: ;
      endcase
      // a sent command opens a fresh reply
      if (send) begin
        count_next    = '0;
        complete_next = 1'b0;
      end
    end
  end

  // Work handed to the queue
  assign push                 = send || pulse;
  assign push_job.kind        = send ? KIND_PACKET : pulse_kind;
  assign push_job.cmd         = cmd;
  assign push_job.param       = param;
  assign push_job.servo_width = lock_next ? cfg.lock_width_b : cfg.lock_width_a;

endmodule

FILE: rtl/fms_queue.sv
// Short job queue between front and back end.
module fms_queue #(
  parameter int DEPTH = fms_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fms_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output fms_pkg::job_t head_job,
  input  logic          pop
);
  import fms_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/fms_back.sv
// Back end: serializes queued jobs into result transfers.
module fms_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  fms_pkg::job_t head_job,
  output logic          pop,
  input  logic [15:0]   device_id,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [1:0]    kind,
  output logic [7:0]    tx_byte,
  output logic          last,
  output logic [15:0]   servo_width
);
  import fms_pkg::*;

  logic [REPLY_IDX_W-1:0] byte_idx;
  logic                   load;
  logic                   is_packet;
  logic                   at_end;
  logic [15:0]            sum;
  logic [7:0]             cur_byte;

  assign is_packet = head_job.kind == KIND_PACKET;
  assign load      = head_valid && (!res_valid || res_ready);
  assign at_end    = !is_packet || byte_idx == REPLY_IDX_W'(PACKET_BYTES - 1);
  assign pop       = load && at_end;

  // Byte-sum checksum over all bytes ahead of it, headers included
  assign sum = 16'(HDR_0) + 16'(HDR_1)
             + {8'd0, device_id[7:0]} + {8'd0, device_id[15:8]}
             + {8'd0, head_job.param[7:0]} + {8'd0, head_job.param[15:8]}
             + {8'd0, head_job.cmd};

  // Packet byte at the current position
  always_comb begin
    case (byte_idx)
      4'd0:    cur_byte = HDR_0;
      4'd1:    cur_byte = HDR_1;
      4'd2:    cur_byte = device_id[7:0];
      4'd3:    cur_byte = device_id[15:8];
      4'd4:    cur_byte = head_job.param[7:0];
      4'd5:    cur_byte = head_job.param[15:8];
      4'd8:    cur_byte = head_job.cmd;
      4'd10:   cur_byte = sum[7:0];
      4'd11:   cur_byte = sum[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  // Byte position within the packet
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (load) begin
      byte_idx <= at_end ? '0 : byte_idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= head_job.kind;
      tx_byte     <= is_packet ? cur_byte : 8'h00;
      last        <= at_end;
      servo_width <= head_job.servo_width;
    end
  end

endmodule

FILE: rtl/fingerprint_module_sequencer_unit.sv
// Top level of the fingerprint module sequencer.
//
//   channel  dir   handshake     payload
//   evt      in    valid/ready   action[2:0], rx_byte[7:0]
//   result   out   valid/ready   kind[1:0], tx_byte[7:0], last, servo_width[15:0]
//   cfg      in    valid/ready   index[1:0], data[15:0]
//
// One event is taken per cycle while the job queue has room; events are
// decoded in the cycle they transfer. A command packet leaves as 12 result
// transfers, one per cycle while the result side is ready, paced by the back
// end's byte counter; a pulse is one transfer. The first result goes through
// the job queue, then the output register. Reset is synchronous; the phase
// starts at clear-all. A stalled result side fills the queue; evt.ready drops.
module fingerprint_module_sequencer_unit #(
  parameter int ENROLL_PASSES = fms_pkg::ENROLL_PASSES,
  parameter int QUEUE_DEPTH   = fms_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  fms_evt_if.sink    evt,
  fms_res_if.source  result,
  fms_cfg_if.sink    cfg
);
  import fms_pkg::*;

  cfg_t cfg_regs;
  logic q_full;
  logic push;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.device_id     <= DEVICE_ID_RST;
      cfg_regs.capture_param <= CAPTURE_RST;
      cfg_regs.lock_width_a  <= LOCK_WIDTH_A_RST;
      cfg_regs.lock_width_b  <= LOCK_WIDTH_B_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DEVICE_ID:    cfg_regs.device_id     <= cfg.data;
        REG_CAPTURE:      cfg_regs.capture_param <= cfg.data[0];
        REG_LOCK_WIDTH_A: cfg_regs.lock_width_a  <= cfg.data;
        REG_LOCK_WIDTH_B: cfg_regs.lock_width_b  <= cfg.data;
        default: ;
      endcase
    end
  end

  fms_front #(
    .ENROLL_PASSES(ENROLL_PASSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .action    (evt.action),
    .rx_byte   (evt.rx_byte),
    .cfg       (cfg_regs),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  fms_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  fms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .device_id   (cfg_regs.device_id),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .kind        (result.kind),
    .tx_byte     (result.tx_byte),
    .last        (result.last),
    .servo_width (result.servo_width)
  );

endmodule

FILE: rtl/fms_checker.sv
// Port-level checks on the result channel of the sequencer, bound to the top.
module fms_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  kind,
  input logic [7:0]  tx_byte,
  input logic        last,
  input logic [15:0] servo_width
);
  import fms_pkg::*;

  // Pulses are single transfers with no byte
  a_pulse_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_PACKET |-> last && tx_byte == 8'h00)
    else $error("pulse result not a lone zero-byte transfer");

  // Only the three defined kinds appear
  a_kind_defined: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> kind == KIND_PACKET || kind == KIND_SUCCESS || kind == KIND_REJECT)
    else $error("undefined result kind");

  // A packet continues after a non-final byte with a packet byte
  a_packet_cont: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && kind == KIND_PACKET && !last
      ##1 res_valid |-> kind == KIND_PACKET)
    else $error("packet interrupted by a pulse");

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(tx_byte)
      && $stable(last) && $stable(servo_width))
    else $error("stalled result changed");

endmodule

bind fingerprint_module_sequencer_unit fms_checker u_fms_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .kind        (result.kind),
  .tx_byte     (result.tx_byte),
  .last        (result.last),
  .servo_width (result.servo_width)
);

FILE: verif/tb_fingerprint_module_sequencer_unit.sv
// Testbench for the fingerprint module sequencer: directed table, dialog-driven random events.
module tb_fingerprint_module_sequencer_unit;
  import fms_pkg::*;

  // Action codes the block ignores
  localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

  // Fixed packets at reset configuration
  localparam logic [95:0] PKT_CLEAR   = 96'h55AA_0100_0000_0000_4100_4101;
  localparam logic [95:0] PKT_LED_OFF = 96'h55AA_0100_0000_0000_1200_1201;
  localparam logic [95:0] PKT_ENR_1   = 96'h55AA_0100_0100_0000_2200_2301;
  localparam logic [95:0] PKT_NONE    = 96'h0;

  localparam int SETTLE_CYCLES = 20;
  localparam int ITEM_CAP      = 500;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] servo;
  } res_t;

  // One directed event; typed rows carry their expected results
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  rx;
    logic        typed;
    logic [3:0]  n;
    kind_t       kind;
    logic [15:0] servo;
    logic [95:0] pkt;
  } stim_row_t;

  localparam stim_row_t DIR_TBL [26] = '{
    '{ACT_TICK,      8'h00, 1'b1, 4'd12, KIND_PACKET,  16'd750,  PKT_CLEAR},
    '{ACT_TICK,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_SPARE_LO,  8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_SPARE_MID, 8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_SPARE_HI,  8'h80, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_UNLOCK,    8'h00, 1'b1, 4'd1,  KIND_SUCCESS, 16'd2000, PKT_NONE},
    '{ACT_UNLOCK,    8'h5A, 1'b1, 4'd1,  KIND_SUCCESS, 16'd750,  PKT_NONE},
    '{ACT_ENROLL,    8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_TICK,      8'h00, 1'b1, 4'd12, KIND_PACKET,  16'd750,  PKT_LED_OFF},
    '{ACT_TICK,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h30, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hFF, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_BYTE,      8'hA5, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    // reply already full: this byte is dropped
    '{ACT_BYTE,      8'h30, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_TICK,      8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE},
    '{ACT_TICK,      8'h00, 1'b1, 4'd12, KIND_PACKET,  16'd750,  PKT_ENR_1},
    '{ACT_VERIFY,    8'h00, 1'b1, 4'd0,  KIND_PACKET,  16'd0,    PKT_NONE}
  };

  logic clk;
  logic rst;

  fms_evt_if evt_ch ();
  fms_res_if res_ch ();
  fms_cfg_if cfg_ch ();

  fingerprint_module_sequencer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Sequencer state as predicted
  phase_t      mod_phase;
  phase_t      mod_after;
  bit          mod_fresh;
  bit          rsp_full;
  int          rsp_cnt;
  logic [7:0]  rsp_buf [PACKET_BYTES];
  logic [15:0] slot_no;
  logic [1:0]  pass_no;
  bit          at_b;
  logic [15:0] id_reg;
  logic        cap_reg;
  logic [15:0] width_a;
  logic [15:0] width_b;

  res_t due_results [$];
  res_t head;
  int   errors;
  int   items_done;
  int   n_packets, n_enrolled, n_granted, n_denied, n_unlocks;
  bit   no_idle;
  int   stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("tb_fingerprint_module_sequencer_unit NOT OK");
    $finish;
  end

  function automatic logic [15:0] servo_now();
    return at_b ? width_b : width_a;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] b, logic fin, ref res_t outs[$]);
    res_t r;
    r.kind    = k;
    r.tx_byte = b;
    r.last    = fin;
    r.servo   = servo_now();
    outs.push_back(r);
  endfunction

  // Build a command packet with its byte-sum trailer; clears the reply store
  function automatic void emit_packet(logic [7:0] cmd, logic [15:0] par, ref res_t outs[$]);
    logic [7:0]  pk [PACKET_BYTES];
    logic [15:0] sum;
    for (int i = 0; i < PACKET_BYTES; i++) pk[i] = 8'h00;
    pk[0] = HDR_0;
    pk[1] = HDR_1;
    pk[2] = id_reg[7:0];
    pk[3] = id_reg[15:8];
    pk[4] = par[7:0];
    pk[5] = par[15:8];
    pk[8] = cmd;
    sum = 16'd0;
    for (int i = 0; i < 10; i++) sum = sum + {8'h00, pk[i]};
    pk[10] = sum[7:0];
    pk[11] = sum[15:8];
    for (int i = 0; i < PACKET_BYTES; i++) rsp_buf[i] = 8'h00;
    rsp_cnt  = 0;
    rsp_full = 1'b0;
    for (int i = 0; i < PACKET_BYTES; i++) emit(KIND_PACKET, pk[i], i == PACKET_BYTES - 1, outs);
    n_packets++;
  endfunction

  function automatic void jump(phase_t p, phase_t a);
    mod_phase = p;
    mod_after = a;
    mod_fresh = 1'b1;
  endfunction

  // Expected results of one event; updates the predicted state
  function automatic void sequencer_step(logic [2:0] act, logic [7:0] rx, ref res_t outs[$]);
    bit ack;
    case (act)
      ACT_TICK: begin
        if (mod_phase == PH_CLEAR) begin
          mod_phase = PH_IDLE;
          emit_packet(CMD_CLEAR, 16'd0, outs);
        end else if (mod_phase >= PH_IDLE) begin
        end else if (mod_fresh) begin
          // first visit: send this phase's command
          mod_fresh = 1'b0;
          case (mod_phase)
            PH_ENR_START: emit_packet(CMD_ENR_START, slot_no, outs);
            PH_LED_ON:    emit_packet(CMD_LED, 16'd1, outs);
            PH_CAPTURE:   emit_packet(CMD_CAPTURE, {15'd0, cap_reg}, outs);
            PH_LED_OFF:   emit_packet(CMD_LED, 16'd0, outs);
            PH_ENR_PASS:  emit_packet(CMD_ENR_PASS + {6'd0, pass_no}, 16'd0, outs);
            PH_IDENT:     emit_packet(CMD_IDENT, 16'd0, outs);
            default:      emit_packet(CMD_PRESS, 16'd0, outs);
          endcase
        end else if (rsp_full) begin
          // later visit: judge the stored reply
          ack = (rsp_buf[8] == ACK_CODE);
          case (mod_phase)
            PH_ENR_START: if (ack) jump(PH_LED_ON, PH_ON_ENR);
            PH_LED_ON, PH_LED_OFF: if (ack) jump(mod_after, mod_after);
            PH_CAPTURE: begin
              if (ack) jump(mod_after, mod_after);
              else mod_fresh = 1'b1;
            end
            PH_ON_ENR, PH_ON_VER: begin
              if (ack) begin
                if (rsp_buf[4] != 8'h00) mod_fresh = 1'b1;
                else if (mod_phase == PH_ON_ENR) jump(PH_CAPTURE, PH_ENR_PASS);
                else jump(PH_CAPTURE, PH_IDENT);
              end
            end
            PH_OFF_ENR, PH_OFF_VER: begin
              if (ack) begin
                if (rsp_buf[4] == 8'h00 && rsp_buf[5] == 8'h00) mod_fresh = 1'b1;
                else if (mod_phase == PH_OFF_ENR) jump(PH_LED_ON, PH_ON_ENR);
                else jump(PH_LED_ON, PH_ON_VER);
              end
            end
            PH_ENR_PASS: begin
              if (!ack) begin
                pass_no = 2'd0;
                jump(PH_LED_OFF, PH_ENR_START);
              end else if (int'(pass_no) + 1 >= ENROLL_PASSES) begin
                jump(PH_LED_OFF, PH_IDLE);
                slot_no = slot_no + 16'd1;
                pass_no = 2'd0;
                emit(KIND_SUCCESS, 8'h00, 1'b1, outs);
                n_enrolled++;
              end else begin
                pass_no = pass_no + 2'd1;
                jump(PH_LED_OFF, PH_OFF_ENR);
              end
            end
            PH_IDENT: begin
              jump(PH_LED_OFF, PH_IDLE);
              if (ack) begin
                at_b = !at_b;
                emit(KIND_SUCCESS, 8'h00, 1'b1, outs);
                n_granted++;
              end else begin
                emit(KIND_REJECT, 8'h00, 1'b1, outs);
                n_denied++;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_BYTE: begin
        if (rsp_cnt < PACKET_BYTES) begin
          rsp_buf[rsp_cnt] = rx;
          rsp_cnt++;
          if (rsp_cnt == PACKET_BYTES) rsp_full = 1'b1;
        end
      end
      ACT_VERIFY: jump(PH_LED_ON, PH_ON_VER);
      ACT_UNLOCK: begin
        at_b = !at_b;
        emit(KIND_SUCCESS, 8'h00, 1'b1, outs);
        n_unlocks++;
      end
      ACT_ENROLL: begin
        mod_phase = PH_LED_OFF;
        mod_after = PH_ENR_START;
      end
      default: ;
    endcase
  endfunction

  // Event transfer, with an optional idle burst first
  task automatic xfer_evt(input logic [2:0] act, input logic [7:0] rx, input bit typed);
    res_t outs [$];
    if (!no_idle && $urandom_range(0, 99) < 12) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    evt_ch.valid   <= 1'b1;
    evt_ch.action  <= act;
    evt_ch.rx_byte <= rx;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    sequencer_step(act, rx, outs);
    if (!typed) foreach (outs[k]) due_results.push_back(outs[k]);
    if (act <= ACT_ENROLL) items_done++;
  endtask

  // Stop sending and let the block drain
  task automatic wait_quiet();
    evt_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_DEVICE_ID:    id_reg  = d;
      REG_CAPTURE:      cap_reg = d[0];
      REG_LOCK_WIDTH_A: width_a = d;
      REG_LOCK_WIDTH_B: width_b = d;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side ready, stalled in random bursts
  initial begin
    res_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 8)
        stall_left = $urandom_range(1, 15);
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none,", $time,
                 " got kind %0d byte %02h last %0b servo %0d",
                 res_ch.kind, res_ch.tx_byte, res_ch.last, res_ch.servo_width);
      end else begin
        head = due_results.pop_front();
        if (res_ch.kind !== head.kind || res_ch.tx_byte !== head.tx_byte ||
            res_ch.last !== head.last || res_ch.servo_width !== head.servo) begin
          errors++;
          $display("%0t: result mismatch: expected kind %0d byte %02h last %0b servo %0d,",
                   $time, head.kind, head.tx_byte, head.last, head.servo,
                   " got kind %0d byte %02h last %0b servo %0d",
                   res_ch.kind, res_ch.tx_byte, res_ch.last, res_ch.servo_width);
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t   row;
    res_t        r;
    logic [15:0] plan [4][4];
    int          pick, idx, cut;
    int          goal;
    bit          go_on;
    logic [7:0]  v;

    rst            <= 1'b1;
    evt_ch.valid   <= 1'b0;
    evt_ch.action  <= ACT_TICK;
    evt_ch.rx_byte <= 8'h00;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_DEVICE_ID;
    cfg_ch.data    <= 16'h0000;
    errors = 0;
    items_done = 0;
    n_packets = 0;
    n_enrolled = 0;
    n_granted = 0;
    n_denied = 0;
    n_unlocks = 0;
    no_idle = 1'b0;

    // predicted state after reset
    mod_phase = PH_CLEAR;
    mod_after = PH_ENR_START;
    mod_fresh = 1'b1;
    rsp_full  = 1'b0;
    rsp_cnt   = 0;
    for (int i = 0; i < PACKET_BYTES; i++) rsp_buf[i] = 8'h00;
    slot_no = 16'd1;
    pass_no = 2'd0;
    at_b    = 1'b0;
    id_reg  = DEVICE_ID_RST;
    cap_reg = CAPTURE_RST;
    width_a = LOCK_WIDTH_A_RST;
    width_b = LOCK_WIDTH_B_RST;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (DIR_TBL[i]) begin
      row = DIR_TBL[i];
      xfer_evt(row.action, row.rx, row.typed);
      if (row.typed) begin
        for (int j = 0; j < int'(row.n); j++) begin
          r.kind    = row.kind;
          r.tx_byte = (row.kind == KIND_PACKET) ? row.pkt[95 - 8 * j -: 8] : 8'h00;
          r.last    = (j == int'(row.n) - 1);
          r.servo   = row.servo;
          due_results.push_back(r);
        end
      end
    end

    // Register settings per phase: device id, capture, width a, width b
    plan = '{'{16'hFFFF, 16'd0, 16'h0000, 16'hFFFF},
             '{16'h0000, 16'd1, 16'hFFFF, 16'h0000},
             '{16'h0000, 16'd0, 16'h0000, 16'h0000},
             '{16'h00A5, 16'd1, 16'd750,  16'd2000}};
    plan[2][0] = 16'($urandom_range(0, 65535));
    plan[2][1] = 16'($urandom_range(0, 1));
    plan[2][2] = 16'($urandom_range(0, 65535));
    plan[2][3] = 16'($urandom_range(0, 65535));

    for (int s = 0; s < 4; s++) begin
      wait_quiet();
      cfg_write(REG_DEVICE_ID, plan[s][0]);
      cfg_write(REG_CAPTURE, plan[s][1]);
      cfg_write(REG_LOCK_WIDTH_A, plan[s][2]);
      cfg_write(REG_LOCK_WIDTH_B, plan[s][3]);
      no_idle = (s == 3);
      goal = items_done + 110;
      while (items_done < ITEM_CAP &&
             (items_done < goal ||
              (s == 3 && (n_enrolled == 0 || n_granted == 0 || n_denied == 0)))) begin
        // choose what comes next from where the dialog stands
        pick = $urandom_range(0, 99);
        if (mod_phase == PH_IDLE)
          pick = pick < 40 ? 2 : pick < 70 ? 3 : pick < 85 ? 4 : 5;
        else if (mod_phase != PH_CLEAR && !mod_fresh && !rsp_full)
          pick = pick < 88 ? 0 : 5;
        else if (mod_phase != PH_CLEAR && !mod_fresh)
          pick = pick < 50 ? 1 : pick < 75 ? 2 : 3;
        else
          pick = pick < 95 ? 1 : 5;

        case (pick)
          0: begin
            // full reply, mostly acknowledged, then the tick that judges it
            go_on = ($urandom_range(0, 99) < 75);
            while (!rsp_full) begin
              idx = rsp_cnt;
              v = 8'($urandom_range(0, 255));
              if (idx == 8 && $urandom_range(0, 99) < 90) v = ACK_CODE;
              if (idx == 4 || idx == 5) begin
                case (mod_phase)
                  PH_ON_ENR, PH_ON_VER: if (idx == 4) v = go_on ? 8'h00 : (v | 8'h01);
                  PH_OFF_ENR, PH_OFF_VER: v = go_on ? (v | 8'h01) : 8'h00;
                  default: ;
                endcase
              end
              xfer_evt(ACT_BYTE, v, 1'b0);
            end
            xfer_evt(ACT_TICK, 8'h00, 1'b0);
          end
          1: xfer_evt(ACT_TICK, 8'($urandom_range(0, 255)), 1'b0);
          2: xfer_evt(ACT_VERIFY, 8'($urandom_range(0, 255)), 1'b0);
          3: xfer_evt(ACT_ENROLL, 8'($urandom_range(0, 255)), 1'b0);
          4: xfer_evt(ACT_UNLOCK, 8'($urandom_range(0, 255)), 1'b0);
          default: begin
            // noise: any action code, or a broken-off reply
            if ($urandom_range(0, 1) == 0) begin
              xfer_evt(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
            end else begin
              cut = $urandom_range(1, 11);
              repeat (cut) xfer_evt(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            end
          end
        endcase

        // occasionally hold off until the block has drained
        if (!no_idle && $urandom_range(0, 199) == 0) wait_quiet();
      end
    end

    wait_quiet();
    $display("Covered %0d events over 4 register settings: %0d command packets, %0d unlocks,",
             items_done, n_packets, n_unlocks);
    $display("%0d finished enrollments, %0d identify grants and %0d identify rejects.",
             n_enrolled, n_granted, n_denied);
    if (errors == 0) begin
      $display("tb_fingerprint_module_sequencer_unit OK");
    end else begin
      $display("tb_fingerprint_module_sequencer_unit NOT OK");
    end
    $finish;
  end

endmodule
